FILE: rtl/sliding_window_mean_assert.svh
// assertion macros for the sliding window mean block
// expects signals named clock and reset in the scope of each use
`ifndef SLIDING_WINDOW_MEAN_ASSERT_SVH
`define SLIDING_WINDOW_MEAN_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SWM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/swm_pkg.sv
// shared constants and types for the sliding window mean block
// no dependencies
package swm_pkg;

   // payload widths fixed by the beat format
   localparam int SAMPLE_W   = 16;
   localparam int HELD_W     = 5;

   // default window depth
   localparam int WINDOW_DEF = 16;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_LOAD,
      ST_DIV,
      ST_FINISH
   } swm_state_type;

endpackage

FILE: rtl/swm_req_if.sv
// request channel carrying one signed sample per beat
// depends on swm_pkg
interface swm_req_if
   import swm_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

FILE: rtl/swm_rsp_if.sv
// response channel carrying the window mean and sample count per beat
// depends on swm_pkg
interface swm_rsp_if
   import swm_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] mean;
   logic        [HELD_W-1:0]   held;

   modport source (output valid, output mean, output held, input ready);
   modport sink   (input valid, input mean, input held, output ready);
endinterface

FILE: rtl/sliding_window_mean.sv
// a request beat is taken only while idle; it then passes update, load, divide
// steps and finish, where its result is registered (SUM_W = 16 + clog2(WINDOW))
// a new sample is taken only after the last one has left finish, and the
// restoring divider retires one quotient bit per cycle
// reset: synchronous, clears window fill, write slot, running sum and the sequencer;
// the sample ring itself is not cleared and is read only after it was written
module sliding_window_mean
   import swm_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic      clock,
   input  logic      reset,
   swm_req_if.sink   req_chan,
   swm_rsp_if.source rsp_chan
);

   localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SLOT_W = $clog2(WINDOW);
   localparam int STEP_W = $clog2(SUM_W);

   // control registers
   swm_state_type state_ff, state_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [SUM_W-1:0]           quo_ff, quo_in;
   logic [CNT_W-1:0]           rem_ff, rem_in;
   logic                       neg_ff, neg_in;
   logic signed [SAMPLE_W-1:0] mean_ff, mean_in;
   logic [HELD_W-1:0]          held_ff, held_in;

   // sample ring
   logic signed [SAMPLE_W-1:0] store_mem [WINDOW];
   logic signed [SAMPLE_W-1:0] old_ff;
   logic                       store_we;

   // datapath helpers
   logic                 req_beat;
   logic                 full;
   logic [SUM_W-1:0]     old_ext;
   logic [SUM_W-1:0]     new_ext;
   logic [CNT_W:0]       trial;
   logic [CNT_W:0]       divisor;
   logic                 fits;
   logic [SAMPLE_W-1:0]  quo_lo;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_beat       = req_chan.valid && req_chan.ready;
   assign full           = (fill_ff == CNT_W'(WINDOW));

   assign old_ext = full ? {{(SUM_W-SAMPLE_W){old_ff[SAMPLE_W-1]}}, old_ff} : '0;
   assign new_ext = {{(SUM_W-SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff};

   // one restoring divider step
   assign trial   = {rem_ff, quo_ff[SUM_W-1]};
   assign divisor = {1'b0, fill_ff};
   assign fits    = (trial >= divisor);
   assign quo_lo  = quo_ff[SAMPLE_W-1:0];

   assign store_we = (state_ff == ST_UPDATE);

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      sample_in    = sample_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      mean_in      = mean_ff;
      held_in      = held_ff;

      // response beat taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               sample_in = req_chan.sample;
               state_in  = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // drop the overwritten sample once full, then add the new one
            sum_in  = $signed(SUM_W'($unsigned(sum_ff) - old_ext + new_ext));
            slot_in = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
            if (!full) begin
               fill_in = fill_ff + 1'b1;
            end
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            // divide the magnitude, fix the sign at the end
            neg_in   = sum_ff[SUM_W-1];
            quo_in   = sum_ff[SUM_W-1] ? SUM_W'(-$unsigned(sum_ff)) : $unsigned(sum_ff);
            rem_in   = '0;
            step_in  = STEP_W'(SUM_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = fits ? CNT_W'(trial - divisor) : trial[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], fits};
            if (step_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_chan.ready) begin
               mean_in      = neg_ff ? $signed(-quo_lo) : $signed(quo_lo);
               held_in      = HELD_W'(fill_ff);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      neg_ff    <= neg_in;
      mean_ff   <= mean_in;
      held_ff   <= held_in;
   end

   // ring write and registered read of the slot about to be overwritten
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[slot_ff] <= sample_ff;
      end
      old_ff <= store_mem[slot_ff];
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.mean  = mean_ff;
   assign rsp_chan.held  = held_ff;

   // checks
   `include "sliding_window_mean_assert.svh"

   `SWM_ASSERT_NEXT(a_beat_starts_update, req_beat, state_ff == ST_UPDATE, "request beat did not start an update")
   `SWM_ASSERT_NOW(a_fill_bounded, 1'b1, fill_ff <= CNT_W'(WINDOW), "fill count above window depth")
   `SWM_ASSERT_NOW(a_rsp_nonempty, rsp_valid_ff, fill_ff != '0, "response with an empty window")
   `SWM_ASSERT_NEXT(a_div_ends, (state_ff == ST_DIV) && (step_ff == '0), state_ff == ST_FINISH, "divider did not finish on its last step")

endmodule
